@@ rtl/khcsd_pkg.sv @@
// Shared constants, item types and keystream arithmetic for the keyed header check decryptor.
`timescale 1ns / 1ps
package khcsd_pkg;

  localparam int KEY_PERIOD_DEF  = 256;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Header layout
  localparam int                HDR_CNT_W    = 5;
  localparam logic [HDR_CNT_W-1:0] HEADER_BYTES = 5'd16;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST_IDX = 5'd15;
  localparam logic [31:0]       MAGIC_WORD   = 32'h4449_4d44;
  localparam logic [31:0]       VERSION_WORD = 32'h0001_0000;

  // Key check
  localparam logic [31:0] KEY_XOR         = 32'h304d_5751;
  localparam logic [31:0] KEY_MUL         = 32'd211;
  localparam logic [31:0] USER_MUL        = 32'd11;
  localparam logic [31:0] KEY_MOD         = 32'd19973;
  localparam int          KEY_RECIP_SHIFT = 46;
  localparam int          KEY_REM_W       = 15;
  localparam logic [31:0] KEY_RECIP       =
    32'((64'd1 << KEY_RECIP_SHIFT) / 64'(KEY_MOD));

  // Keystream
  localparam logic [31:0] STREAM_XOR         = 32'h9a87_df9f;
  localparam logic [31:0] STREAM_MUL         = 32'd13;
  localparam logic [31:0] STREAM_MOD         = 32'h0005_4781;
  localparam int          STREAM_RECIP_SHIFT = 48;
  localparam logic [31:0] STREAM_RECIP       =
    32'((64'd1 << STREAM_RECIP_SHIFT) / 64'(STREAM_MOD));
  // A stepped keystream value is below STREAM_MOD / 4, so it fits in 17 bits.
  localparam int          STREAM_T_W   = 17;
  localparam int          STREAM_V_W   = 21;
  localparam int          STREAM_MAX_QUOT = 5;
  localparam logic [31:0] STREAM_XOR_HI =
    STREAM_XOR & ~32'((64'd1 << STREAM_T_W) - 64'd1);
  localparam logic [31:0] STREAM_BASE = 32'(64'(STREAM_XOR_HI) * 64'(STREAM_MUL));
  localparam logic [31:0] STREAM_BASE_MOD = STREAM_BASE % STREAM_MOD;

  // Cycles the input is held off after a user identifier write while the seed settles.
  localparam int          SEED_SETTLE_CYCLES = 4;

  // Configuration register indexes
  localparam int                    CFG_INDEX_W    = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_USER_ID    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_ONLY = 1'd1;

  // Item kinds passed from the front to the back
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_SHORT   = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FORMAT = 2'd1;
  localparam logic [1:0] ST_USER   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic        restart;
    logic        fmt_ok;
    logic [31:0] key_word;
    logic [31:0] size;
  } qe_t;

  typedef struct packed {
    logic signed [31:0] user_id;
    logic               check_only;
  } cfg_t;

  // One keystream step from a previously stepped value. The upper bits of the
  // operand are fixed by the XOR constant, so the high part of the product is a
  // constant and the low part never carries past bit 31; the remainder reduces
  // to a constant offset plus a short compare and subtract.
  function automatic logic [STREAM_T_W-1:0] stream_next(input logic [STREAM_T_W-1:0] t);
    logic [STREAM_V_W-1:0] v;
    logic [STREAM_V_W-1:0] r;
    v = STREAM_V_W'(STREAM_BASE_MOD)
        + STREAM_V_W'(t ^ STREAM_XOR[STREAM_T_W-1:0]) * STREAM_V_W'(STREAM_MUL);
    r = v;
    for (int k = 1; k <= STREAM_MAX_QUOT; k++) begin
      if (v >= STREAM_V_W'(32'(k) * STREAM_MOD)) begin
        r = v - STREAM_V_W'(32'(k) * STREAM_MOD);
      end
    end
    return r[STREAM_T_W+1:2];
  endfunction

endpackage

@@ rtl/khcsd_in_if.sv @@
// Input byte channel interface.
`timescale 1ns / 1ps
interface khcsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

@@ rtl/khcsd_out_if.sv @@
// Result channel interface.
`timescale 1ns / 1ps
interface khcsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_status;
  logic [1:0]  status_code;
  logic [31:0] payload_length;
  logic        end_of_file;

  modport source (output valid, out_byte, is_status, status_code, payload_length,
                  end_of_file, input ready);
  modport sink (input valid, out_byte, is_status, status_code, payload_length,
                end_of_file, output ready);
endinterface

@@ rtl/khcsd_cfg_if.sv @@
// Configuration write channel interface.
`timescale 1ns / 1ps
interface khcsd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [khcsd_pkg::CFG_INDEX_W-1:0] index;
  logic [31:0]                        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/keyed_header_check_stream_decrypt_top.sv @@
// Top level of the keyed header check and stream decryptor.
`timescale 1ns / 1ps
// Takes a file one byte per item and accepts a new item every cycle while the
// result side keeps up and no user_id write is settling. Each file opens with
// a 16-byte header (magic, version, key check, payload size); the 16th byte, or
// an earlier last byte, yields one status item, and each later byte yields one
// decrypted item unless the header failed or check-only mode is set. A result
// passes from its accepted input item through the queue between the header
// front end and the back end, five stages that compute the key check
// remainder, and the output register. The sustained rate of one byte per cycle
// is set by the keystream step, which is computed combinationally ahead of the
// first back-end stage. After user_id is written, the keystream seed settles
// through the seed pipeline, and the input is held off while the settle counter
// runs down so that every item accepted later already sees the new seed.
module keyed_header_check_stream_decrypt_top #(
  parameter int KEY_PERIOD  = khcsd_pkg::KEY_PERIOD_DEF,
  parameter int QUEUE_DEPTH = khcsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  khcsd_in_if.sink    in_ch,
  khcsd_out_if.source out_ch,
  khcsd_cfg_if.sink   cfg_ch
);

  khcsd_pkg::cfg_t cfg_r, cfg_nxt;
  khcsd_pkg::qe_t  push_entry;
  khcsd_pkg::qe_t  head;
  logic            push;
  logic            q_full;
  logic            head_valid;
  logic            pop;
  logic [2:0]      settle_r, settle_nxt;
  logic            front_stall;

  assign cfg_ch.ready = 1'b1;
  assign front_stall  = q_full || (settle_r != 3'd0);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        khcsd_pkg::REG_USER_ID:    cfg_nxt.user_id    = $signed(cfg_ch.data);
        khcsd_pkg::REG_CHECK_ONLY: cfg_nxt.check_only = cfg_ch.data[0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_comb begin
    settle_nxt = settle_r;
    if (cfg_ch.valid && cfg_ch.ready && (cfg_ch.index == khcsd_pkg::REG_USER_ID)) begin
      settle_nxt = 3'(khcsd_pkg::SEED_SETTLE_CYCLES);
    end else if (settle_r != 3'd0) begin
      settle_nxt = settle_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.user_id    <= '0;
      cfg_r.check_only <= 1'b0;
      settle_r         <= 3'd0;
    end else begin
      cfg_r    <= cfg_nxt;
      settle_r <= settle_nxt;
    end
  end

  khcsd_front #(
    .KEY_PERIOD (KEY_PERIOD)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (front_stall),
    .push   (push),
    .entry  (push_entry)
  );

  khcsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  khcsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ rtl/khcsd_front.sv @@
// Front part: gathers the header, tracks the keystream position and classifies items.
`timescale 1ns / 1ps
module khcsd_front #(
  parameter int KEY_PERIOD = khcsd_pkg::KEY_PERIOD_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  khcsd_in_if.sink         in_ch,
  input  logic             q_full,
  output logic             push,
  output khcsd_pkg::qe_t   entry
);

  localparam int POS_W = (KEY_PERIOD > 1) ? $clog2(KEY_PERIOD) : 1;

  logic [khcsd_pkg::HDR_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0]                pos_r, pos_nxt;
  logic [POS_W:0]                  pos_inc;
  logic [3:0][3:0][7:0]            hdr_r;
  logic                            acc;
  logic                            in_hdr;
  logic                            hdr_done;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign in_hdr      = (cnt_r != khcsd_pkg::HEADER_BYTES);
  assign hdr_done    = (cnt_r == khcsd_pkg::HDR_LAST_IDX);
  assign pos_inc     = {1'b0, pos_r} + {{POS_W{1'b0}}, 1'b1};

  always_comb begin
    push           = acc && (!in_hdr || hdr_done || in_ch.last_byte);
    entry.data     = in_ch.data_byte;
    entry.last     = in_ch.last_byte;
    entry.restart  = (pos_r == '0);
    entry.fmt_ok   = (hdr_r[0] == khcsd_pkg::MAGIC_WORD) &&
                     (hdr_r[1] == khcsd_pkg::VERSION_WORD);
    entry.key_word = hdr_r[2];
    entry.size     = {in_ch.data_byte, hdr_r[3][2], hdr_r[3][1], hdr_r[3][0]};
    if (!in_hdr) begin
      entry.kind = khcsd_pkg::KIND_PAYLOAD;
    end else if (hdr_done) begin
      entry.kind = khcsd_pkg::KIND_STATUS;
    end else begin
      entry.kind = khcsd_pkg::KIND_SHORT;
    end

    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    if (acc) begin
      if (in_hdr) begin
        cnt_nxt = cnt_r + 1'b1;
      end else if (pos_inc >= (POS_W + 1)'(KEY_PERIOD)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_inc[POS_W-1:0];
      end
      // The byte after the last one of a file starts a new header.
      if (in_ch.last_byte) begin
        cnt_nxt = '0;
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_hdr) begin
      hdr_r[cnt_r[3:2]][cnt_r[1:0]] <= in_ch.data_byte;
    end
  end

endmodule

@@ rtl/khcsd_queue.sv @@
// Short item queue between the front and back parts.
`timescale 1ns / 1ps
module khcsd_queue #(
  parameter int DEPTH = khcsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  khcsd_pkg::qe_t push_entry,
  output logic           full,
  input  logic           pop,
  output khcsd_pkg::qe_t head,
  output logic           head_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  khcsd_pkg::qe_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue read while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue fill count out of range");

  a_cnt_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue fill count did not follow a write");

endmodule

@@ rtl/khcsd_back.sv @@
// Back part: keystream, key check pipeline, payload drop decision and result register.
`timescale 1ns / 1ps
module khcsd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  khcsd_pkg::cfg_t  cfg,
  input  khcsd_pkg::qe_t   head,
  input  logic             head_valid,
  output logic             pop,
  khcsd_out_if.source      out_ch
);

  localparam int TW = khcsd_pkg::STREAM_T_W;
  localparam int RW = khcsd_pkg::KEY_REM_W;

  logic en;

  // Keystream seed pipeline, rerun continuously from the user identifier.
  logic [31:0]   sd_x_r, sd_p_r, sd_p2_r, sd_p3_r, sd_qm_r;
  logic [63:0]   sd_prod_r;
  logic [31:0]   sd_d, sd_red;
  logic [TW-1:0] seed_t_r;
  logic [31:0]   user11_r;

  // Keystream state
  logic [TW-1:0] t_r, t_nxt;
  logic          t_load;

  // Item stages
  khcsd_pkg::qe_t   s1_in;
  logic             s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  khcsd_pkg::qe_t   s1_it_r, s2_it_r, s3_it_r, s4_it_r, s5_it_r;
  logic [31:0]      s1_r_r;
  logic             s2_neg_r, s3_neg_r, s4_neg_r, s5_neg_r;
  logic [31:0]      s2_mag_r, s3_mag_r, s4_mag_r;
  logic [63:0]      s3_prod_r;
  logic [31:0]      s4_qd_r;
  logic [31:0]      s5_d;
  logic [31:0]      s5_red;
  logic [RW-1:0]    s5_m_r;

  // Result stage
  logic [31:0] kc;
  logic        emit;
  logic [1:0]  code_nxt;
  logic [31:0] len_nxt;
  logic        rejected_r, rejected_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_is_status_r;
  logic [1:0]  out_code_r;
  logic [31:0] out_len_r;
  logic        out_eof_r;

  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && head_valid;

  // Seed: step(user_id * 13) with a full 32-bit remainder by reciprocal.
  assign sd_d   = sd_p3_r - sd_qm_r;
  assign sd_red = (sd_d >= khcsd_pkg::STREAM_MOD) ? sd_d - khcsd_pkg::STREAM_MOD : sd_d;

  always_ff @(posedge clk) begin
    sd_x_r    <= ($unsigned(cfg.user_id) * khcsd_pkg::STREAM_MUL) ^ khcsd_pkg::STREAM_XOR;
    sd_p_r    <= sd_x_r * khcsd_pkg::STREAM_MUL;
    sd_prod_r <= 64'(sd_p_r) * 64'(khcsd_pkg::STREAM_RECIP);
    sd_p2_r   <= sd_p_r;
    sd_qm_r   <= 32'(sd_prod_r[63:khcsd_pkg::STREAM_RECIP_SHIFT]) * khcsd_pkg::STREAM_MOD;
    sd_p3_r   <= sd_p2_r;
    seed_t_r  <= sd_red[TW+1:2];
    user11_r  <= $unsigned(cfg.user_id) * khcsd_pkg::USER_MUL;
  end

  // The keystream recurrence closes through t_r alone; it restarts from the seed.
  assign t_load = pop && (head.kind == khcsd_pkg::KIND_PAYLOAD);
  assign t_nxt  = head.restart ? seed_t_r : khcsd_pkg::stream_next(t_r);

  always_ff @(posedge clk) begin
    if (t_load) begin
      t_r <= t_nxt;
    end
  end

  always_comb begin
    s1_in      = head;
    s1_in.data = head.data ^ t_nxt[7:0];
  end

  // Key check stages: mix, magnitude, reciprocal multiply, quotient product, remainder.
  assign s5_d   = s4_mag_r - s4_qd_r;
  assign s5_red = (s5_d >= khcsd_pkg::KEY_MOD) ? s5_d - khcsd_pkg::KEY_MOD : s5_d;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_it_r      <= s1_in;
      s1_r_r       <= ((head.size ^ khcsd_pkg::KEY_XOR) * khcsd_pkg::KEY_MUL) ^ user11_r;

      s2_it_r  <= s1_it_r;
      s2_neg_r <= s1_r_r[31];
      s2_mag_r <= s1_r_r[31] ? 32'd0 - s1_r_r : s1_r_r;

      s3_it_r   <= s2_it_r;
      s3_neg_r  <= s2_neg_r;
      s3_mag_r  <= s2_mag_r;
      s3_prod_r <= 64'(s2_mag_r) * 64'(khcsd_pkg::KEY_RECIP);

      s4_it_r  <= s3_it_r;
      s4_neg_r <= s3_neg_r;
      s4_mag_r <= s3_mag_r;
      s4_qd_r  <= 32'(s3_prod_r[63:khcsd_pkg::KEY_RECIP_SHIFT]) * khcsd_pkg::KEY_MOD;

      s5_it_r  <= s4_it_r;
      s5_neg_r <= s4_neg_r;
      s5_m_r   <= s5_red[RW-1:0];
    end
  end

  // Result: the remainder takes the sign of the dividend.
  assign kc = s5_neg_r ? 32'd0 - {{(32 - RW){1'b0}}, s5_m_r} : {{(32 - RW){1'b0}}, s5_m_r};

  always_comb begin
    code_nxt = khcsd_pkg::ST_OK;
    len_nxt  = 32'd0;
    emit     = 1'b0;
    case (s5_it_r.kind)
      khcsd_pkg::KIND_STATUS: begin
        emit = 1'b1;
        if (!s5_it_r.fmt_ok) begin
          code_nxt = khcsd_pkg::ST_FORMAT;
        end else if (kc != s5_it_r.key_word) begin
          code_nxt = khcsd_pkg::ST_USER;
        end else begin
          len_nxt = s5_it_r.size;
        end
      end
      khcsd_pkg::KIND_SHORT: begin
        emit     = 1'b1;
        code_nxt = khcsd_pkg::ST_FORMAT;
      end
      khcsd_pkg::KIND_PAYLOAD: begin
        emit = !rejected_r && !cfg.check_only;
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    rejected_nxt  = rejected_r;
    out_valid_nxt = out_valid_r;
    if (en) begin
      out_valid_nxt = s5_v_r && emit;
      if (s5_v_r) begin
        if (s5_it_r.last) begin
          rejected_nxt = 1'b0;
        end else if (s5_it_r.kind == khcsd_pkg::KIND_STATUS) begin
          rejected_nxt = (code_nxt != khcsd_pkg::ST_OK);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      rejected_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        s1_v_r <= head_valid;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
        s4_v_r <= s3_v_r;
        s5_v_r <= s4_v_r;
      end
      rejected_r  <= rejected_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_is_status_r <= (s5_it_r.kind != khcsd_pkg::KIND_PAYLOAD);
      out_byte_r      <= (s5_it_r.kind == khcsd_pkg::KIND_PAYLOAD) ? s5_it_r.data : 8'd0;
      out_code_r      <= code_nxt;
      out_len_r       <= len_nxt;
      out_eof_r       <= s5_it_r.last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.is_status      = out_is_status_r;
  assign out_ch.status_code    = out_code_r;
  assign out_ch.payload_length = out_len_r;
  assign out_ch.end_of_file    = out_eof_r;

  a_rejected_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s5_v_r && (s5_it_r.kind == khcsd_pkg::KIND_STATUS) && !s5_it_r.last &&
     (code_nxt != khcsd_pkg::ST_OK)) |=> rejected_r)
    else $error("failed header did not block the payload");

  a_eof_clears_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s5_v_r && s5_it_r.last) |=> !rejected_r)
    else $error("reject flag survived the end of a file");

  a_error_no_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_status_r && (out_code_r != khcsd_pkg::ST_OK))
      |-> (out_len_r == 32'd0))
    else $error("error status carries a payload length");

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_is_status_r)
      |-> ((out_code_r == khcsd_pkg::ST_OK) && (out_len_r == 32'd0)))
    else $error("payload item carries status fields");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the keyed header check stream decryptor.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_status;
    logic [1:0]  status_code;
    logic [31:0] payload_length;
    logic        end_of_file;
  } result_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  khcsd_in_if  in_bus();
  khcsd_out_if out_bus();
  khcsd_cfg_if cfg_bus();

  keyed_header_check_stream_decrypt_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, starting from its reset values.
  logic [31:0] model_user = 32'h0;
  logic        model_check_only = 1'b0;
  logic [4:0]  hdr_count = 5'd0;
  logic [31:0] hdr_word [4] = '{32'h0, 32'h0, 32'h0, 32'h0};
  logic        hdr_rejected = 1'b0;
  logic [31:0] ks_value = 32'h0;
  int          ks_pos = 0;

  result_t awaited_results[$];
  bit      no_idle = 1'b0;
  int      mismatches = 0;
  int      items_sent = 0;
  int      files_sent = 0;
  int      status_seen [3] = '{0, 0, 0};
  int      bytes_seen = 0;

  function automatic result_t mk_result(input logic [7:0] b, input logic st,
                                        input logic [1:0] code, input logic [31:0] len,
                                        input logic eof);
    result_t r;
    r.out_byte       = b;
    r.is_status      = st;
    r.status_code    = code;
    r.payload_length = len;
    r.end_of_file    = eof;
    return r;
  endfunction

  // The key check is a signed remainder, so it truncates toward zero.
  function automatic logic [31:0] expected_key(input logic [31:0] user, input logic [31:0] size);
    logic [31:0] mixed;
    mixed = ((size ^ khcsd_pkg::KEY_XOR) * khcsd_pkg::KEY_MUL) ^ (user * khcsd_pkg::USER_MUL);
    return 32'($signed(mixed) % $signed(khcsd_pkg::KEY_MOD));
  endfunction

  function automatic logic [31:0] ks_step(input logic [31:0] t);
    logic [31:0] prod;
    prod = (t ^ khcsd_pkg::STREAM_XOR) * khcsd_pkg::STREAM_MUL;
    return (prod % khcsd_pkg::STREAM_MOD) >> 2;
  endfunction

  task automatic predict_decrypt(input logic [7:0] data, input logic last,
                                 output logic made, output result_t r);
    logic [31:0] seed;
    logic [31:0] t;
    logic [1:0]  code;
    logic [31:0] len;
    made = 1'b0;
    r = '0;
    if (hdr_count < khcsd_pkg::HEADER_BYTES) begin
      hdr_word[hdr_count[3:2]][{hdr_count[1:0], 3'b000} +: 8] = data;
      hdr_count++;
      if (hdr_count == khcsd_pkg::HEADER_BYTES) begin
        code = khcsd_pkg::ST_OK;
        len  = 32'h0;
        if (hdr_word[0] != khcsd_pkg::MAGIC_WORD || hdr_word[1] != khcsd_pkg::VERSION_WORD) begin
          code = khcsd_pkg::ST_FORMAT;
        end else if (hdr_word[2] != expected_key(model_user, hdr_word[3])) begin
          code = khcsd_pkg::ST_USER;
        end else begin
          len = hdr_word[3];
        end
        hdr_rejected = (code != khcsd_pkg::ST_OK);
        made = 1'b1;
        r = mk_result(8'h00, 1'b1, code, len, last);
      end else if (last) begin
        made = 1'b1;
        r = mk_result(8'h00, 1'b1, khcsd_pkg::ST_FORMAT, 32'h0, 1'b1);
      end
    end else begin
      // The keystream advances even when the payload item is dropped.
      seed = (ks_pos == 0) ? model_user * khcsd_pkg::STREAM_MUL : ks_value;
      t = ks_step(seed);
      ks_value = t;
      ks_pos = (ks_pos + 1 >= khcsd_pkg::KEY_PERIOD_DEF) ? 0 : ks_pos + 1;
      if (!hdr_rejected && !model_check_only) begin
        made = 1'b1;
        r = mk_result(data ^ t[7:0], 1'b0, khcsd_pkg::ST_OK, 32'h0, last);
      end
    end
    if (last) begin
      hdr_count    = 5'd0;
      hdr_rejected = 1'b0;
      ks_pos       = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last,
                           input bit typed, input result_t want);
    logic    made;
    result_t predicted;
    while (!no_idle && $urandom_range(99) < 34) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= data;
    in_bus.last_byte <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent++;
    predict_decrypt(data, last, made, predicted);
    if (typed) begin
      awaited_results.push_back(want);
    end else if (made) begin
      awaited_results.push_back(predicted);
    end
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic write_config(input logic [31:0] user, input logic check_only);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= khcsd_pkg::REG_USER_ID;
    cfg_bus.data  <= user;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    model_user = user;
    cfg_bus.index <= khcsd_pkg::REG_CHECK_ONLY;
    cfg_bus.data  <= 32'(check_only);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    model_check_only = check_only;
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_file(input bit long_payload);
    logic [31:0] word [4];
    logic [7:0]  file [$];
    int          roll;
    int          payload_len;
    roll = $urandom_range(99);
    case ($urandom_range(3))
      0: word[3] = 32'h0;
      1: word[3] = 32'hffff_ffff;
      default: word[3] = $urandom();
    endcase
    word[0] = khcsd_pkg::MAGIC_WORD;
    word[1] = khcsd_pkg::VERSION_WORD;
    word[2] = expected_key(model_user, word[3]);
    // Most files carry a sound header; the rest break one field, are noise or stop short.
    if (roll < 8) begin
      word[2][$urandom_range(31)] ^= 1'b1;
    end else if (roll < 14) begin
      word[0][$urandom_range(31)] ^= 1'b1;
    end else if (roll < 19) begin
      word[1][$urandom_range(31)] ^= 1'b1;
    end else if (roll < 22) begin
      foreach (word[i]) word[i] = $urandom();
    end
    for (int i = 0; i < 16; i++) file.push_back(word[i / 4][(i % 4) * 8 +: 8]);
    if (roll >= 22 && roll < 28) begin
      file = file[0:$urandom_range(14)];
    end else begin
      if (long_payload) begin
        payload_len = $urandom_range(300, 257);
      end else begin
        payload_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(24, 1);
      end
      repeat (payload_len) file.push_back(8'($urandom_range(255)));
    end
    foreach (file[i]) send_byte(file[i], i == file.size() - 1, 1'b0, '0);
    files_sent++;
  endtask

  always @(posedge clk) begin
    result_t got, want;
    out_bus.ready <= no_idle || ($urandom_range(99) >= 34);
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = mk_result(out_bus.out_byte, out_bus.is_status, out_bus.status_code,
                      out_bus.payload_length, out_bus.end_of_file);
      if (got.is_status) begin
        status_seen[got.status_code]++;
      end else begin
        bytes_seen++;
      end
      if (awaited_results.size() == 0) begin
        report_mismatch("unawaited result byte", 32'(got.out_byte), 32'h0);
      end else begin
        want = awaited_results.pop_front();
        if (got.out_byte !== want.out_byte)
          report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
        if (got.is_status !== want.is_status)
          report_mismatch("is_status", 32'(got.is_status), 32'(want.is_status));
        if (got.status_code !== want.status_code)
          report_mismatch("status_code", 32'(got.status_code), 32'(want.status_code));
        if (got.payload_length !== want.payload_length)
          report_mismatch("payload_length", got.payload_length, want.payload_length);
        if (got.end_of_file !== want.end_of_file)
          report_mismatch("end_of_file", 32'(got.end_of_file), 32'(want.end_of_file));
      end
    end
  end

  initial begin
    result_t     fmt_eof;
    result_t     ok_zero;
    stim_row_t   directed_rows[$];
    logic [31:0] hw [4];
    logic [31:0] phase_user [6];
    bit          phase_check [6];
    int          budget;
    int          waited;

    in_bus.valid     = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.last_byte = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = khcsd_pkg::REG_USER_ID;
    cfg_bus.data     = 32'h0;
    out_bus.ready    = 1'b0;

    fmt_eof = mk_result(8'h00, 1'b1, khcsd_pkg::ST_FORMAT, 32'h0, 1'b1);
    ok_zero = mk_result(8'h00, 1'b1, khcsd_pkg::ST_OK, 32'h0, 1'b0);
    hw[0] = khcsd_pkg::MAGIC_WORD;
    hw[1] = khcsd_pkg::VERSION_WORD;
    hw[2] = expected_key(32'h0, 32'h0);
    hw[3] = 32'h0;

    // A one-byte file, a sound header for the reset user with three payload
    // items (both byte extremes, then 5a), then a two-byte file that ends too early.
    directed_rows.push_back('{8'h00, 1'b1, 1'b1, fmt_eof});
    for (int i = 0; i < 16; i++)
      directed_rows.push_back('{hw[i / 4][(i % 4) * 8 +: 8], 1'b0, i == 15, ok_zero});
    directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'hff, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'h5a, 1'b1, 1'b0, '0});
    directed_rows.push_back('{8'hff, 1'b0, 1'b0, '0});
    directed_rows.push_back('{8'hff, 1'b1, 1'b1, fmt_eof});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);

    phase_user  = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, $urandom(), $urandom()};
    phase_check = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      // Dropped payload items may still be in the pipeline with nothing to show for it.
      repeat (10) @(posedge clk);
      write_config(phase_user[p], phase_check[p]);
      no_idle = (p == 2);
      budget = items_sent + 260;
      send_file(p == 0 || p == 4);
      while (items_sent < budget) begin
        if ($urandom_range(49) == 0) wait_drained();
        send_file($urandom_range(39) == 0);
      end
    end

    in_bus.valid <= 1'b0;
    waited = 0;
    while (awaited_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (12) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", 32'(awaited_results.size()), 32'h0);

    $display("Sent %0d bytes: a directed opening plus %0d generated files over six configurations.",
             items_sent, files_sent);
    $display("Checked %0d ok, %0d format and %0d bad-user statuses and %0d payload bytes.",
             status_seen[0], status_seen[1], status_seen[2], bytes_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop in case the design hangs.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
rtl/khcsd_pkg.sv
rtl/khcsd_in_if.sv
rtl/khcsd_out_if.sv
rtl/khcsd_cfg_if.sv
rtl/khcsd_front.sv
rtl/khcsd_queue.sv
rtl/khcsd_back.sv
rtl/keyed_header_check_stream_decrypt_top.sv
tb/testbench.sv
